@@ hw/rtl/i2csbe_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C slave bit engine package
// Shared types and constants: engine state, configuration and register codes.
// ----------------------------------------------------------------------------
package i2csbe_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgOwnAddress  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAddressMask = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTransmit    = 2'd2;

  localparam logic [7:0] OwnAddressReset  = 8'd0;
  localparam logic [7:0] AddressMaskReset = 8'd254;
  localparam logic [7:0] TransmitReset    = 8'd66;

  localparam logic [7:0] TopBit = 8'h80;
  localparam logic [7:0] LowBit = 8'h01;

  // Word widths on the stream channels
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  typedef struct packed {
    logic [7:0] own_address;
    logic [7:0] address_mask;
    logic [7:0] transmit_byte;
  } cfg_t;

  typedef struct packed {
    logic       last_scl;
    logic       last_sda;
    logic       active;
    logic       start_armed;
    logic       data_phase;
    logic       read_direction;
    logic       sending;
    logic [7:0] shift_reg;
    logic [7:0] bit_mask;
    logic [7:0] byte_count;
    logic [7:0] data_latch;
    logic       pull_low;
    logic       pin_out;
    logic       rise_en;
    logic       fall_en;
    logic       ack_wait;
    logic       snap_data;
  } state_t;

  localparam state_t StateReset = '{
    last_scl:       1'b1,
    last_sda:       1'b1,
    active:         1'b0,
    start_armed:    1'b0,
    data_phase:     1'b0,
    read_direction: 1'b0,
    sending:        1'b0,
    shift_reg:      8'd0,
    bit_mask:       8'd0,
    byte_count:     8'd0,
    data_latch:     8'd0,
    pull_low:       1'b0,
    pin_out:        1'b0,
    rise_en:        1'b1,
    fall_en:        1'b1,
    ack_wait:       1'b0,
    snap_data:      1'b0
  };

endpackage

@@ hw/rtl/i2csbe_core.sv @@
// ----------------------------------------------------------------------------
// I2C slave bit engine core
// Next-state logic for one SCL/SDA sample: edge detection, start arming,
// address/data shifting, acknowledge and byte transmission.
// ----------------------------------------------------------------------------
module i2csbe_core (
  input  i2csbe_pkg::state_t st_i,
  input  i2csbe_pkg::cfg_t   cfg_i,
  input  logic               scl_i,
  input  logic               sda_i,
  output i2csbe_pkg::state_t st_o,
  output logic               rx_valid_o
);
  import i2csbe_pkg::*;

  // Puts the next transmit bit on the line, or releases it after the byte.
  function automatic state_t drive_bit(input state_t s_in);
    state_t s;
    s = s_in;
    if (s.bit_mask == 8'd0) begin
      s.pull_low = 1'b0;
      s.fall_en  = 1'b0;
      s.rise_en  = 1'b1;
    end else begin
      s.pull_low = ~s.shift_reg[7];
    end
    s.shift_reg = {s.shift_reg[6:0], 1'b0};
    s.bit_mask  = {1'b0, s.bit_mask[7:1]};
    return s;
  endfunction

  function automatic state_t load_send(input state_t s_in, input cfg_t c);
    state_t s;
    s = s_in;
    s.shift_reg  = c.transmit_byte;
    s.bit_mask   = TopBit;
    s.sending    = 1'b1;
    s.byte_count = s.byte_count + 8'd1;
    return s;
  endfunction

  function automatic state_t on_rise(input state_t s_in, input cfg_t c, input logic sda);
    state_t s;
    s = s_in;
    if (!s.read_direction) begin
      if (sda) begin
        s.shift_reg = s.shift_reg | s.bit_mask;
      end
      if (s.bit_mask == LowBit) begin
        if (!s.data_phase && ((s.shift_reg & c.address_mask) != c.own_address)) begin
          s.active     = 1'b0;
          s.data_phase = 1'b1;
          s.rise_en    = 1'b0;
          s.fall_en    = 1'b1;
        end else begin
          s.ack_wait = 1'b1;
        end
      end
      s.bit_mask = {1'b0, s.bit_mask[7:1]};
    end else begin
      // Master acknowledge slot: NACK ends the read, ACK asks for another byte.
      if (sda) begin
        s.read_direction = 1'b0;
        s.sending        = 1'b0;
      end else begin
        s = load_send(s, c);
      end
      s.rise_en = 1'b0;
      s.fall_en = 1'b1;
    end
    return s;
  endfunction

  function automatic state_t on_fall(input state_t s_in, input cfg_t c);
    state_t s;
    s = s_in;
    if (s.sending) begin
      s = drive_bit(s);
    end else begin
      if (s.start_armed) begin
        s.shift_reg      = 8'd0;
        s.start_armed    = 1'b0;
        s.data_phase     = 1'b0;
        s.read_direction = 1'b0;
        s.snap_data      = 1'b0;
        s.bit_mask       = TopBit;
        s.byte_count     = 8'd0;
        s.fall_en        = 1'b0;
        s.rise_en        = 1'b1;
      end else if (s.bit_mask == 8'd0) begin
        s.pull_low = 1'b0;
        if (s.snap_data) begin
          s.pin_out = s.data_latch[0];
        end
        s.snap_data = s.data_phase;
        if (s.read_direction) begin
          s = load_send(s, c);
        end else begin
          s.shift_reg  = 8'd0;
          s.bit_mask   = TopBit;
          s.byte_count = s.byte_count + 8'd1;
          s.fall_en    = 1'b0;
          s.rise_en    = 1'b1;
        end
      end
      if (s.read_direction) begin
        s = drive_bit(s);
      end
    end
    return s;
  endfunction

  logic rise, fall;

  always_comb begin
    st_o       = st_i;
    rx_valid_o = 1'b0;
    rise       = scl_i & ~st_i.last_scl;
    fall       = ~scl_i & st_i.last_scl;
    if (st_i.ack_wait) begin
      if (fall) begin
        st_o.ack_wait = 1'b0;
        st_o.pull_low = 1'b1;
        if (st_i.data_phase) begin
          st_o.data_latch = st_i.shift_reg;
          rx_valid_o      = 1'b1;
        end else begin
          st_o.data_phase = 1'b1;
          if (st_i.shift_reg[0]) begin
            st_o.read_direction = 1'b1;
          end
        end
        st_o.rise_en = 1'b0;
        st_o.fall_en = 1'b1;
      end
    end else if ((rise && st_i.rise_en) || (fall && st_i.fall_en)) begin
      if (st_i.active) begin
        if (rise) begin
          st_o = on_rise(st_i, cfg_i, sda_i);
        end else begin
          st_o = on_fall(st_i, cfg_i);
        end
      end
    end else if (st_i.last_sda && !sda_i && scl_i && !st_i.pull_low) begin
      st_o.start_armed = 1'b1;
      st_o.active      = 1'b1;
      st_o.rise_en     = 1'b1;
      st_o.fall_en     = 1'b1;
    end
    st_o.last_scl = scl_i;
    st_o.last_sda = sda_i;
  end

endmodule

@@ hw/rtl/i2c_slave_bit_engine.sv @@
// ----------------------------------------------------------------------------
// I2C slave bit engine
// Oversampled I2C slave with a 7-bit address and selectable direction.
// ----------------------------------------------------------------------------
// Usage
//   The input stream carries one word per sample of the bus lines: bit 0 is
//   the SCL level and bit 1 the SDA level. For every accepted word the block
//   returns exactly one word on the output stream with the SDA drive, the
//   addressing and direction flags, the last received byte, a pulse marking
//   a newly latched byte, the byte count since the start and the user pin.
//   The configuration port writes the own address, the address mask and the
//   byte sent on reads; the user must write it only while no word is in
//   flight, as the block itself does not enforce this. The accepting edge
//   loads the input register, and the result register is loaded from it
//   through the next-state logic once that is free. Throughput is one word
//   per cycle unless stalled, set by the core's single-pass state update.
//   The input register takes a new word whenever its contents move on, so a
//   stalled receiver backs up at most two words and then deasserts
//   s_axis_tready; nothing is lost or repeated.
//   Reset clears both stream stages, restores the register defaults and puts
//   the engine in its released, unaddressed state with both lines seen high.
// ----------------------------------------------------------------------------
module i2c_slave_bit_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [i2csbe_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [7:0]                         cfg_data_i,
  // Sample stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] scl_level, [1] sda_level, [7:2] zero
  input  logic [i2csbe_pkg::InDataW-1:0]     s_axis_tdata,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] sda_pull_low, [1] is_addressed, [2] master_reading,
  // [10:3] received_byte, [11] received_valid, [19:12] bytes_done,
  // [20] user_pin, [23:21] zero
  output logic [i2csbe_pkg::OutDataW-1:0]    m_axis_tdata
);
  import i2csbe_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  logic   rx_valid;

  logic   in_vld_q;
  logic   in_scl_q, in_sda_q;
  logic   out_vld_q;
  logic [OutDataW-1:0] out_data_q;

  logic   advance;
  logic   in_take;

  // The result register is free when empty or being emptied this cycle.
  assign advance = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign in_take = s_axis_tvalid && s_axis_tready;

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address   <= OwnAddressReset;
      cfg_q.address_mask  <= AddressMaskReset;
      cfg_q.transmit_byte <= TransmitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgOwnAddress:  cfg_q.own_address   <= cfg_data_i;
        CfgAddressMask: cfg_q.address_mask  <= cfg_data_i;
        CfgTransmit:    cfg_q.transmit_byte <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_scl_q <= s_axis_tdata[0];
      in_sda_q <= s_axis_tdata[1];
    end
  end

  i2csbe_core u_core (
    .st_i       (state_q),
    .cfg_i      (cfg_q),
    .scl_i      (in_scl_q),
    .sda_i      (in_sda_q),
    .st_o       (state_d),
    .rx_valid_o (rx_valid)
  );

  // Engine state moves only when its word moves into the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'b000, state_d.pin_out, state_d.byte_count, rx_valid,
                     state_d.data_latch, state_d.read_direction, state_d.active,
                     state_d.pull_low};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // A latched byte is always acknowledged in the same word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[11]) |-> m_axis_tdata[0])
    else $error("received byte reported without acknowledge drive");

  // Waiting to acknowledge implies the transfer is still addressed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.ack_wait |-> state_q.active)
    else $error("acknowledge pending while not addressed");

  // The engine state only changes when a word enters the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("engine state changed without a word moving on");

endmodule
